>>> hw/rtl/xmt_pkg.sv
// shared types, character codes and keyword matching for the markup tokenizer
`timescale 1ns / 1ps
`default_nettype none
package xmt_pkg;

	typedef enum logic [3:0] {
		KIND_COMMENT_OPEN  = 4'd0,
		KIND_COMMENT_CLOSE = 4'd1,
		KIND_END_OPEN      = 4'd2,
		KIND_EMPTY_CLOSE   = 4'd3,
		KIND_OPEN          = 4'd4,
		KIND_CLOSE         = 4'd5,
		KIND_EQUALS        = 4'd6,
		KIND_QUOTE         = 4'd7,
		KIND_DQUOTE        = 4'd8,
		KIND_SPACE         = 4'd9,
		KIND_STRING        = 4'd10,
		KIND_NONE          = 4'd15
	} kind_t;

	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	localparam int unsigned WIN_BYTES = 4;

	// window towards the labeller: byte 0 is the one being labelled
	typedef struct packed {
		logic [WIN_BYTES-1:0][7:0] bytes;
		logic [2:0]                avail;
		logic                      last;
	} win_t;

	typedef struct packed {
		logic       hit;
		kind_t      kind;
		logic [1:0] extra;
	} kw_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CH_SP) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

	// first keyword in priority order that lies wholly inside the window
	function automatic kw_t kw_match(input win_t w);
		kw_t r;
		r = '{hit: 1'b1, kind: KIND_NONE, extra: 2'd0};
		if (w.avail >= 3'd4 && w.bytes[0] == CH_LT && w.bytes[1] == CH_BANG &&
				w.bytes[2] == CH_DASH && w.bytes[3] == CH_DASH) begin
			r.kind = KIND_COMMENT_OPEN;
			r.extra = 2'd3;
		end else if (w.avail >= 3'd3 && w.bytes[0] == CH_DASH && w.bytes[1] == CH_DASH &&
				w.bytes[2] == CH_GT) begin
			r.kind = KIND_COMMENT_CLOSE;
			r.extra = 2'd2;
		end else if (w.avail >= 3'd2 && w.bytes[0] == CH_LT && w.bytes[1] == CH_SLASH) begin
			r.kind = KIND_END_OPEN;
			r.extra = 2'd1;
		end else if (w.avail >= 3'd2 && w.bytes[0] == CH_SLASH && w.bytes[1] == CH_GT) begin
			r.kind = KIND_EMPTY_CLOSE;
			r.extra = 2'd1;
		end else if (w.bytes[0] == CH_LT) begin
			r.kind = KIND_OPEN;
		end else if (w.bytes[0] == CH_GT) begin
			r.kind = KIND_CLOSE;
		end else if (w.bytes[0] == CH_EQ) begin
			r.kind = KIND_EQUALS;
		end else if (w.bytes[0] == CH_QUOTE) begin
			r.kind = KIND_QUOTE;
		end else if (w.bytes[0] == CH_DQUOTE) begin
			r.kind = KIND_DQUOTE;
		end else begin
			r.hit = 1'b0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/xmt_window.sv
// four-byte lookahead window with end-of-stream flush control
`timescale 1ns / 1ps
`default_nettype none
module xmt_window (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [7:0]    in_byte,
	input  wire logic          in_end,
	output xmt_pkg::win_t      win,
	output logic               win_valid,
	input  wire logic          win_ready
);
	import xmt_pkg::*;

	logic [WIN_BYTES-1:0][7:0] hold_q;
	logic [WIN_BYTES-1:0][7:0] hold_n;
	logic [2:0]                cnt_q;
	logic [2:0]                cnt_n;
	logic [2:0]                cnt_shift;
	logic                      fl_q;
	logic                      lab_fire;
	logic                      in_take;

	assign win_valid = (cnt_q == 3'd4) || (fl_q && cnt_q != 3'd0);
	assign win.bytes = hold_q;
	assign win.avail = cnt_q;
	assign win.last  = fl_q && (cnt_q == 3'd1);

	assign lab_fire = win_valid && win_ready;
	assign in_stall = fl_q || ((cnt_q == 3'd4) && !lab_fire);
	assign in_take  = in_valid && !in_stall;

	assign cnt_shift = cnt_q - {2'b00, lab_fire};
	assign cnt_n     = cnt_shift + {2'b00, in_take};

	always_comb begin
		hold_n = hold_q;
		if (lab_fire) begin
			for (int i = 0; i < WIN_BYTES - 1; i++) begin
				hold_n[i] = hold_q[i+1];
			end
		end
		if (in_take) begin
			hold_n[cnt_shift[1:0]] = in_byte;
		end
	end

	always_ff @(posedge clk) begin
		hold_q <= hold_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			fl_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_n;
			if (in_take && in_end) begin
				fl_q <= 1'b1;
			end else if (lab_fire && win.last) begin
				fl_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/xmt_label.sv
// token labelling state and result register
`timescale 1ns / 1ps
`default_nettype none
module xmt_label (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire xmt_pkg::win_t win,
	input  wire logic          win_valid,
	output logic               win_ready,
	output logic               res_valid,
	input  wire logic          res_stall,
	output logic [7:0]         res_byte,
	output logic [3:0]         res_kind,
	output logic               res_start,
	output logic               res_last
);
	import xmt_pkg::*;

	kind_t      cur_q;
	kind_t      cur_n;
	logic [1:0] kbl_q;
	logic [1:0] kbl_n;
	kind_t      kind;
	logic       start;
	logic       ws;
	kw_t        kw;
	logic       fire;

	assign ws = is_ws(win.bytes[0]);
	assign kw = kw_match(win);

	always_comb begin
		kbl_n = kbl_q;
		if (kbl_q != 2'd0) begin
			kind  = cur_q;
			start = 1'b0;
			kbl_n = kbl_q - 2'd1;
		end else if (cur_q == KIND_SPACE && ws) begin
			kind  = KIND_SPACE;
			start = 1'b0;
		end else if (cur_q == KIND_STRING && !ws && !kw.hit) begin
			kind  = KIND_STRING;
			start = 1'b0;
		end else begin
			start = 1'b1;
			if (kw.hit) begin
				kind  = kw.kind;
				kbl_n = kw.extra;
			end else begin
				kind = ws ? KIND_SPACE : KIND_STRING;
			end
		end
		cur_n = kind;
		// end of stream: next byte opens a fresh stream
		if (win.last) begin
			cur_n = KIND_NONE;
			kbl_n = 2'd0;
		end
	end

	assign win_ready = !res_valid || !res_stall;
	assign fire      = win_valid && win_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= KIND_NONE;
			kbl_q     <= 2'd0;
			res_valid <= 1'b0;
		end else begin
			if (fire) begin
				cur_q <= cur_n;
				kbl_q <= kbl_n;
			end
			if (fire) begin
				res_valid <= 1'b1;
			end else if (!res_stall) begin
				res_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_byte  <= win.bytes[0];
			res_kind  <= kind;
			res_start <= start;
			res_last  <= win.last;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/xml_markup_byte_tokenizer_top.sv
// top level of the markup byte tokenizer
`timescale 1ns / 1ps
`default_nettype none
// Labels a markup byte stream with token kinds and token-start flags, one result
// per byte, in stream order. A byte is labelled once three later bytes are held
// (or the stream ends), so the first result appears four transfers into a
// stream. In steady flow the block takes one byte and gives one result per cycle;
// the byte window and the result register decouple the two channels, so input
// keeps flowing while a result waits on tok_stall until the window is full.
// The transfer that carries stream_end starts a flush: the held bytes and the
// final byte are labelled one per cycle while tok_stall is low, text_stall stays
// high during that flush, and the last result carries last_out. After a flush
// the tokenizer state is back at reset and the next byte opens a new stream.
// Keyword matching is done in fixed priority against the window, and a keyword
// only matches when all its bytes are present, so a partial keyword at the end
// of a stream is labelled as the shorter keywords and strings within it.
module xml_markup_byte_tokenizer_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// byte input channel
	input  wire logic       text_valid,
	output logic            text_stall,
	input  wire logic [7:0] text_byte,
	input  wire logic       stream_end,
	// labelled byte channel
	output logic            tok_valid,
	input  wire logic       tok_stall,
	output logic [7:0]      byte_out,
	output logic [3:0]      token_kind,
	output logic            token_start,
	output logic            last_out
);
	import xmt_pkg::*;

	win_t win;
	logic win_valid;
	logic win_ready;

	// lookahead window and flush sequencing
	xmt_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (text_valid),
		.in_stall  (text_stall),
		.in_byte   (text_byte),
		.in_end    (stream_end),
		.win       (win),
		.win_valid (win_valid),
		.win_ready (win_ready)
	);

	// labelling logic and result register
	xmt_label u_label (
		.clk       (clk),
		.arst_n    (arst_n),
		.win       (win),
		.win_valid (win_valid),
		.win_ready (win_ready),
		.res_valid (tok_valid),
		.res_stall (tok_stall),
		.res_byte  (byte_out),
		.res_kind  (token_kind),
		.res_start (token_start),
		.res_last  (last_out)
	);

	// a result never carries the idle kind
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> (token_kind <= 4'd10))
		else $error("result with illegal token kind");

	// the window never offers a byte it does not hold
	a_win_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		win_valid |-> (win.avail != 3'd0 && win.avail <= 3'd4))
		else $error("window offered with bad fill");

	// the final byte transfer must start a flush that blocks input
	a_end_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(text_valid && !text_stall && stream_end) |=> text_stall)
		else $error("input not held off after stream end");

	// a flush always ends with a labelled last byte
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(win_valid && win_ready && win.last) |=> (tok_valid && last_out))
		else $error("last byte not flagged at result");

endmodule
`default_nettype wire

>>> verif/tb_xml_markup_byte_tokenizer_top.sv
// self-checking testbench for the markup byte tokenizer: directed keyword streams, random markup and noise
`timescale 1ns / 1ps
module tb_xml_markup_byte_tokenizer_top;
	import xmt_pkg::*;

	// generous ceiling: every byte waiting out the longest sender gap and receiver stall, many times over
	localparam int CYCLE_LIMIT = 200000;
	// cycles allowed for stray results once nothing more is expected
	localparam int DRAIN_CYCLES = 20;
	localparam int MARKUP_ITEMS = 250;
	localparam int NOISE_ITEMS = 100;
	localparam int PRINT_CAP = 100;

	// one labelled byte as the block should present it
	typedef struct {
		logic [7:0] ch;
		kind_t      kind;
		bit         first;
		bit         closing;
	} label_t;

	logic       clk;
	logic       arst_n;
	logic       text_valid;
	logic       text_stall;
	logic [7:0] text_byte;
	logic       stream_end;
	logic       tok_valid;
	logic       tok_stall;
	logic [7:0] byte_out;
	logic [3:0] token_kind;
	logic       token_start;
	logic       last_out;

	// labels still owed by the block, oldest first
	label_t labels_due[$];

	// tokenizer state as the checker sees it
	logic [2:0][7:0] held;
	int              held_n;
	int              keyword_left;
	kind_t           run_kind;

	int   mismatches;
	int   cycles;
	int   bytes_sent;
	int   tx_calm;
	int   rx_calm;
	int   stall_left;
	logic [7:0] doc_q[$];

	xml_markup_byte_tokenizer_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text_byte  (text_byte),
		.stream_end (stream_end),
		.tok_valid  (tok_valid),
		.tok_stall  (tok_stall),
		.byte_out   (byte_out),
		.token_kind (token_kind),
		.token_start(token_start),
		.last_out   (last_out)
	);

	always #1 clk = ~clk;

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// mostly short gaps, a few long ones, and now and then a calm stretch with none
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
	endtask

	function automatic bit is_blank(input logic [7:0] b);
		return b == CH_SP || (b >= CH_TAB && b <= CH_CR);
	endfunction

	// highest-priority keyword lying wholly within the first n bytes of the window
	function automatic kind_t find_word(input logic [3:0][7:0] w, input int n, output int len);
		len = 1;
		if (n >= 4 && w[0] == CH_LT && w[1] == CH_BANG && w[2] == CH_DASH && w[3] == CH_DASH) begin
			len = 4;
			return KIND_COMMENT_OPEN;
		end
		if (n >= 3 && w[0] == CH_DASH && w[1] == CH_DASH && w[2] == CH_GT) begin
			len = 3;
			return KIND_COMMENT_CLOSE;
		end
		if (n >= 2 && w[0] == CH_LT && w[1] == CH_SLASH) begin
			len = 2;
			return KIND_END_OPEN;
		end
		if (n >= 2 && w[0] == CH_SLASH && w[1] == CH_GT) begin
			len = 2;
			return KIND_EMPTY_CLOSE;
		end
		case (w[0])
			CH_LT:     return KIND_OPEN;
			CH_GT:     return KIND_CLOSE;
			CH_EQ:     return KIND_EQUALS;
			CH_QUOTE:  return KIND_QUOTE;
			CH_DQUOTE: return KIND_DQUOTE;
			default: begin
				len = 0;
				return KIND_NONE;
			end
		endcase
	endfunction

	// label the oldest byte of the window and queue the expected result
	task automatic label_next(input logic [3:0][7:0] w, input int n, input bit closing);
		kind_t  hit;
		kind_t  k;
		int     len;
		bit     first;
		label_t item;
		hit = find_word(w, n, len);
		if (keyword_left > 0) begin
			// still inside a multi-byte keyword
			k = run_kind;
			first = 1'b0;
			keyword_left--;
		end else if (run_kind == KIND_SPACE && is_blank(w[0])) begin
			k = KIND_SPACE;
			first = 1'b0;
		end else if (run_kind == KIND_STRING && !is_blank(w[0]) && hit == KIND_NONE) begin
			k = KIND_STRING;
			first = 1'b0;
		end else begin
			first = 1'b1;
			if (hit != KIND_NONE) begin
				k = hit;
				keyword_left = len - 1;
			end else begin
				k = is_blank(w[0]) ? KIND_SPACE : KIND_STRING;
			end
		end
		run_kind = k;
		item.ch = w[0];
		item.kind = k;
		item.first = first;
		item.closing = closing;
		labels_due.push_back(item);
	endtask

	task automatic clear_tokenizer();
		held = '0;
		held_n = 0;
		keyword_left = 0;
		run_kind = KIND_NONE;
	endtask

	// account for one accepted byte: label what now has three bytes behind it, or flush at the end
	task automatic absorb_byte(input logic [7:0] b, input bit e);
		logic [3:0][7:0] win;
		int n;
		win = '0;
		for (int i = 0; i < held_n; i++)
			win[i] = held[i];
		win[held_n] = b;
		n = held_n + 1;
		if (e) begin
			for (int i = 0; i < n; i++)
				label_next(win >> (8 * i), n - i, i == n - 1);
			clear_tokenizer();
		end else if (n == 4) begin
			label_next(win, 4, 1'b0);
			for (int i = 0; i < 3; i++)
				held[i] = win[i + 1];
			held_n = 3;
		end else begin
			for (int i = 0; i < n; i++)
				held[i] = win[i];
			held_n = n;
		end
	endtask

	// present one byte, hold it until the transfer, then maybe leave a gap
	task automatic send_byte(input logic [7:0] b, input bit e);
		int gap;
		text_valid <= 1'b1;
		text_byte <= b;
		stream_end <= e;
		do
			@(posedge clk);
		while (text_stall);
		absorb_byte(b, e);
		bytes_sent++;
		gap = pick_gap(tx_calm);
		if (gap > 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_text(input string s, input bit close_stream);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], close_stream && i == s.len() - 1);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			doc_q.push_back(s[i]);
	endtask

	task automatic add_name();
		int n;
		n = $urandom_range(1, 5);
		for (int i = 0; i < n; i++)
			doc_q.push_back(8'($urandom_range(0, 5) == 0 ? 8'h30 + $urandom_range(0, 9)
				: 8'h61 + $urandom_range(0, 25)));
	endtask

	task automatic add_blank();
		int n;
		n = $urandom_range(1, 3);
		for (int i = 0; i < n; i++)
			doc_q.push_back(8'($urandom_range(0, 1) ? CH_SP : 8'h09 + $urandom_range(0, 4)));
	endtask

	// all multi-byte keywords, a partial comment open at the end, and flushes of three and four bytes
	task automatic test_keywords();
		send_text("<!-", 1'b1);
		send_text("<!--=-->", 1'b1);
		send_byte(CH_LT, 1'b0);
		send_byte(CH_SLASH, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_SLASH, 1'b0);
		send_byte(CH_GT, 1'b1);
	endtask

	// quotes, vertical tab, zero byte, and streams of one and two bytes
	task automatic test_short_streams();
		send_byte(CH_DQUOTE, 1'b0);
		send_byte(CH_QUOTE, 1'b0);
		send_byte(8'h0B, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(CH_SP, 1'b1);
		send_byte(8'h0C, 1'b0);
		send_byte(CH_GT, 1'b1);
	endtask

	// random but mostly well-formed markup, one stream per document
	task automatic test_markup_streams();
		int stop_at;
		int frags;
		logic [7:0] q;
		stop_at = bytes_sent + MARKUP_ITEMS;
		while (bytes_sent < stop_at) begin
			doc_q.delete();
			frags = $urandom_range(1, 6);
			for (int f = 0; f < frags; f++) begin
				case ($urandom_range(0, 9))
					0: begin
						add_text("<");
						add_name();
					end
					1: begin
						add_text("</");
						add_name();
						add_text(">");
					end
					2: add_text("/>");
					3: add_text(">");
					4: begin
						// attribute with either quote style
						q = $urandom_range(0, 1) ? CH_QUOTE : CH_DQUOTE;
						add_blank();
						add_name();
						add_text("=");
						doc_q.push_back(q);
						add_name();
						doc_q.push_back(q);
					end
					5: begin
						add_text("<!--");
						if ($urandom_range(0, 1))
							add_blank();
						add_name();
						add_text("-->");
					end
					6: add_blank();
					7: add_name();
					8: doc_q.push_back(8'($urandom_range(0, 255)));
					default: begin
						// fragments of keywords, which often land at the stream end
						case ($urandom_range(0, 3))
							0: add_text("-");
							1: add_text("--");
							2: add_text("<!");
							default: add_text("<!-");
						endcase
					end
				endcase
			end
			for (int i = 0; i < doc_q.size(); i++)
				send_byte(doc_q[i], i == doc_q.size() - 1);
		end
	endtask

	// uniform random bytes with stream ends scattered through them
	task automatic test_byte_noise();
		for (int i = 0; i < NOISE_ITEMS; i++)
			send_byte(8'($urandom_range(0, 255)),
				i == NOISE_ITEMS - 1 || $urandom_range(0, 7) == 0);
	endtask

	// receiver side: random stall runs
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			tok_stall <= 1'b1;
		end else begin
			stall_left = pick_gap(rx_calm);
			tok_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// every result transfer is checked against the oldest label owed
	always @(posedge clk) begin
		label_t want;
		if (arst_n && tok_valid && !tok_stall) begin
			if (labels_due.size() == 0) begin
				report_mismatch("result with none expected, byte", byte_out, 0);
			end else begin
				want = labels_due.pop_front();
				if (byte_out !== want.ch)
					report_mismatch("byte_out", byte_out, want.ch);
				if (token_kind !== want.kind)
					report_mismatch("token_kind", token_kind, want.kind);
				if (token_start !== want.first)
					report_mismatch("token_start", token_start, want.first);
				if (last_out !== want.closing)
					report_mismatch("last_out", last_out, want.closing);
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		text_valid = 1'b0;
		text_byte = 8'h00;
		stream_end = 1'b0;
		tok_stall = 1'b0;
		mismatches = 0;
		cycles = 0;
		bytes_sent = 0;
		tx_calm = 0;
		rx_calm = 0;
		stall_left = 0;
		clear_tokenizer();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_keywords();
		test_short_streams();
		test_markup_streams();
		test_byte_noise();

		text_valid <= 1'b0;
		stream_end <= 1'b0;
		// drain whatever is still owed, then give stray results a chance to show
		while (labels_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
